// ===== hw/rtl/sms_pkg.sv =====
// Shared types and constants of the substring match scorer.
`timescale 1ns / 1ps

package sms_pkg;

  // Query storage and history line sizes, fixed by the register layout.
  localparam int QUERY_BYTES = 16;
  localparam int HIST_DEPTH  = 15;

  // Width and limit of the reported score.
  localparam int SCORE_W     = 13;
  localparam int SCORE_LIMIT = 8191;

  // Configuration register indexes.
  localparam logic [1:0] REG_QUERY_LOW  = 2'd0;
  localparam logic [1:0] REG_QUERY_HIGH = 2'd1;
  localparam logic [1:0] REG_QUERY_LEN  = 2'd2;

  // One entry byte request.
  typedef struct packed {
    logic [7:0] entry_byte;
    logic       byte_present;
    logic       last_of_entry;
  } in_t;

  // One result request.
  typedef struct packed {
    logic               matched;
    logic [SCORE_W-1:0] rank_score;
  } out_t;

endpackage

// ===== hw/rtl/substring_match_scorer.sv =====
// Top level of the substring match scorer: entry state, query registers, result register.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_stall      byte_item   (sms_pkg::in_t)
//   result    out        result_valid / result_stall  result_item (sms_pkg::out_t)
//   config    in         cfg_write                    cfg_index, cfg_data
//
// One entry byte is taken per cycle unless a last-of-entry request is stalled; the window
// compare and the state update finish in the cycle a byte request is accepted, and the result
// is registered. The result appears in the cycle after the last byte of an entry is accepted.
// Reset is synchronous and clears the query registers and the entry state.
// Only a last-of-entry request is stalled, and only while a result is still held.
`timescale 1ns / 1ps

module substring_match_scorer #(
  parameter int MAX_QUERY_BYTES = 16,
  parameter int MAX_ENTRY_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  sms_pkg::in_t  byte_item,
  output logic          result_valid,
  input  logic          result_stall,
  output sms_pkg::out_t result_item,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  localparam int PW   = $clog2(MAX_ENTRY_BYTES + 1);
  localparam int FW   = $clog2(MAX_ENTRY_BYTES);
  localparam int SUMW = (PW + 1 > sms_pkg::SCORE_W + 1) ? PW + 1 : sms_pkg::SCORE_W + 1;
  localparam int HD   = sms_pkg::HIST_DEPTH;

  // Query registers.
  logic [63:0] query_low_bytes;
  logic [63:0] query_high_bytes;
  logic [4:0]  query_length;

  // Entry state.
  logic [HD-1:0][7:0] recent_bytes;
  logic [PW-1:0]      byte_position;
  logic               match_seen;
  logic [FW-1:0]      first_match_start;

  logic [HD-1:0][7:0] recent_bytes_next;
  logic [PW-1:0]      byte_position_next;
  logic               match_seen_next;
  logic [FW-1:0]      first_match_start_next;

  logic                                  accept;
  logic                                  take;
  logic                                  usable;
  logic                                  hit;
  logic [PW-1:0]                         count;
  logic [sms_pkg::QUERY_BYTES-1:0][7:0]  window;
  logic [sms_pkg::QUERY_BYTES-1:0][7:0]  query;
  logic [SUMW-1:0]                       score_sum;
  sms_pkg::out_t                         result_next;

  // A last-of-entry request waits while the held result is not taken.
  assign byte_stall = result_valid && result_stall && byte_item.last_of_entry;
  assign accept     = byte_valid && !byte_stall;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_low_bytes  <= '0;
      query_high_bytes <= '0;
      query_length     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sms_pkg::REG_QUERY_LOW:  query_low_bytes  <= cfg_data;
        sms_pkg::REG_QUERY_HIGH: query_high_bytes <= cfg_data;
        sms_pkg::REG_QUERY_LEN:  query_length     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // The newest byte and the history line form the compare window.
  assign query  = {query_high_bytes, query_low_bytes};
  assign window = {recent_bytes, byte_item.entry_byte};

  sms_window_match u_match (
    .window       (window),
    .query        (query),
    .query_length (query_length),
    .hit          (hit)
  );

  assign usable = (query_length != 5'd0) && (query_length <= 5'(MAX_QUERY_BYTES));
  assign take   = byte_item.byte_present && (byte_position < PW'(MAX_ENTRY_BYTES));
  assign count  = byte_position + PW'(1);

  // Entry state update for one byte, including the first-match capture.
  always_comb begin
    recent_bytes_next      = recent_bytes;
    byte_position_next     = byte_position;
    match_seen_next        = match_seen;
    first_match_start_next = first_match_start;
    if (take) begin
      if (!match_seen && usable && (count >= PW'(query_length)) && hit) begin
        match_seen_next        = 1'b1;
        first_match_start_next = FW'(count - PW'(query_length));
      end
      recent_bytes_next  = {recent_bytes[HD-2:0], byte_item.entry_byte};
      byte_position_next = count;
    end
  end

  // Result of an entry, from the state after its last byte.
  assign score_sum = SUMW'(first_match_start_next) + SUMW'(byte_position_next)
                   - SUMW'(query_length);

  always_comb begin
    result_next = '0;
    if (query_length == 5'd0) begin
      result_next.matched = 1'b1;
    end else if (usable && (PW'(query_length) <= byte_position_next) && match_seen_next) begin
      result_next.matched = 1'b1;
      if (score_sum > SUMW'(sms_pkg::SCORE_LIMIT)) begin
        result_next.rank_score = sms_pkg::SCORE_W'(sms_pkg::SCORE_LIMIT);
      end else begin
        result_next.rank_score = score_sum[sms_pkg::SCORE_W-1:0];
      end
    end
  end

  // Entry state registers; the last byte of an entry clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes      <= '0;
      byte_position     <= '0;
      match_seen        <= 1'b0;
      first_match_start <= '0;
    end else if (accept) begin
      if (byte_item.last_of_entry) begin
        recent_bytes      <= '0;
        byte_position     <= '0;
        match_seen        <= 1'b0;
        first_match_start <= '0;
      end else begin
        recent_bytes      <= recent_bytes_next;
        byte_position     <= byte_position_next;
        match_seen        <= match_seen_next;
        first_match_start <= first_match_start_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && byte_item.last_of_entry) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_item.last_of_entry) begin
      result_item <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A fresh result only follows an accepted last byte.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(accept && byte_item.last_of_entry))
    else $error("result raised without a last-of-entry request");

  // A miss always reports a zero score.
  a_miss_score: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_item.matched) |-> (result_item.rank_score == '0))
    else $error("nonzero score on a miss");

  // The entry state starts over after each entry.
  a_entry_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_item.last_of_entry) |=> (byte_position == '0 && !match_seen))
    else $error("entry state not cleared after last byte");

  // The byte count saturates at the entry limit.
  a_position_limit: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PW'(MAX_ENTRY_BYTES))
    else $error("byte position beyond entry limit");
`endif

endmodule

// ===== hw/rtl/sms_window_match.sv =====
// Compares the newest query-length bytes of the entry with the query.
`timescale 1ns / 1ps

module sms_window_match (
  input  logic [sms_pkg::QUERY_BYTES-1:0][7:0] window,
  input  logic [sms_pkg::QUERY_BYTES-1:0][7:0] query,
  input  logic [4:0]                           query_length,
  output logic                                 hit
);

  // Window slot d holds the byte d places before the newest one, and it lines
  // up with query byte query_length-1-d. Slots at or beyond the length are ignored.
  always_comb begin
    logic [4:0] idx;
    hit = 1'b1;
    for (int d = 0; d < sms_pkg::QUERY_BYTES; d++) begin
      idx = query_length - 5'd1 - 5'(d);
      if ((5'(d) < query_length) && (query[idx[3:0]] != window[d])) begin
        hit = 1'b0;
      end
    end
  end

endmodule
